[rtl/clx_pkg.sv]
package clx_pkg;

	localparam int POS_BITS_DEF = 24;

	localparam int QDEPTH    = 8;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	localparam logic [3:0] TOK_EOF   = 4'd0;
	localparam logic [3:0] TOK_OPEN  = 4'd1;
	localparam logic [3:0] TOK_CLOSE = 4'd2;
	localparam logic [3:0] TOK_STMT  = 4'd3;
	localparam logic [3:0] TOK_VAR   = 4'd4;
	localparam logic [3:0] TOK_ANY   = 4'd5;
	localparam logic [3:0] TOK_ARITY = 4'd6;
	localparam logic [3:0] TOK_NAME  = 4'd7;
	localparam logic [3:0] TOK_EQUAL = 4'd8;
	localparam logic [3:0] TOK_NUM   = 4'd9;
	localparam logic [3:0] TOK_ERR   = 4'd10;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_VAR_ALN = 3'd1;
	localparam logic [2:0] ERR_ANY_ALN = 3'd2;
	localparam logic [2:0] ERR_BANG    = 3'd3;
	localparam logic [2:0] ERR_UNKNOWN = 3'd4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [3:0]  kind;
		logic [23:0] start;
		logic [23:0] length;
		logic [2:0]  err;
		logic        last;
	} clx_tok_t;

	typedef struct packed {
		logic [1:0] n;
		clx_tok_t   t0;
		clx_tok_t   t1;
	} clx_push_t;

endpackage

[rtl/clx_byte_if.sv]
interface clx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink (input valid, input char_byte, output ready);
endinterface

[rtl/clx_tok_if.sv]
interface clx_tok_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [23:0] token_start;
	logic [23:0] token_length;
	logic [2:0]  error_kind;
	logic        last_of_run;

	modport source (output valid, output token_kind, output token_start, output token_length,
		output error_kind, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_start, input token_length,
		input error_kind, input last_of_run, output ready);
endinterface

[rtl/clx_core.sv]
module clx_core import clx_pkg::*; #(
	parameter int POS_BITS = POS_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [7:0]           char_byte,
	output logic                 in_ready,
	input  logic [QCNT_BITS-1:0] q_count,
	output clx_push_t            push
);

	typedef enum logic [3:0] {
		M_IDLE, M_VAR, M_ANY, M_SLASH, M_EQ, M_CMP, M_BANG, M_NAME, M_NUM, M_ERR
	} mode_t;

	mode_t               mode_q, mode_d, f_mode;
	logic [POS_BITS-1:0] start_q, start_d, pos_q, pos_d;
	logic                valid_s1;
	logic [7:0]          byte_s1;

	logic        is_dig, is_up, is_low, is_aln, is_sp;
	logic [31:0] pos_w, start_w, diff_w;
	logic        f_emit, use_f, t0_v;
	logic [3:0]  f_kind;
	logic [2:0]  f_err;
	clx_tok_t    f_tok, t0;

	assign in_ready = valid_s1 ? (q_count <= QCNT_BITS'(QDEPTH - 4))
		: (q_count <= QCNT_BITS'(QDEPTH - 2));

	assign is_dig = (byte_s1 >= 8'h30) && (byte_s1 <= 8'h39);
	assign is_up  = (byte_s1 >= 8'h41) && (byte_s1 <= 8'h5a);
	assign is_low = (byte_s1 >= 8'h61) && (byte_s1 <= 8'h7a);
	assign is_aln = is_dig || is_up || is_low;
	assign is_sp  = (byte_s1 == CH_SPACE) || ((byte_s1 >= 8'h09) && (byte_s1 <= 8'h0d));

	assign pos_w   = 32'(pos_q);
	assign start_w = 32'(start_q);
	assign diff_w  = 32'(pos_q - start_q);

	always_comb begin
		f_emit = 1'b1;
		f_err  = ERR_NONE;
		f_mode = M_IDLE;
		f_kind = TOK_NAME;
		if (byte_s1 == CH_NUL) begin
			f_kind = TOK_EOF;
		end else if (is_sp) begin
			f_emit = 1'b0;
		end else if (byte_s1 == CH_LPAR) begin
			f_kind = TOK_OPEN;
		end else if (byte_s1 == CH_RPAR) begin
			f_kind = TOK_CLOSE;
		end else if (byte_s1 == CH_SEMI) begin
			f_kind = TOK_STMT;
		end else if (byte_s1 == CH_PLUS || byte_s1 == CH_MINUS || byte_s1 == CH_STAR) begin
			f_kind = TOK_NAME;
		end else if (is_low) begin
			f_emit = 1'b0;
			f_mode = M_VAR;
		end else if (byte_s1 == CH_UNDER) begin
			f_emit = 1'b0;
			f_mode = M_ANY;
		end else if (byte_s1 == CH_SLASH) begin
			f_emit = 1'b0;
			f_mode = M_SLASH;
		end else if (byte_s1 == CH_EQ) begin
			f_emit = 1'b0;
			f_mode = M_EQ;
		end else if (byte_s1 == CH_LT || byte_s1 == CH_GT) begin
			f_emit = 1'b0;
			f_mode = M_CMP;
		end else if (byte_s1 == CH_BANG) begin
			f_emit = 1'b0;
			f_mode = M_BANG;
		end else if (is_up) begin
			f_emit = 1'b0;
			f_mode = M_NAME;
		end else if (is_dig) begin
			f_emit = 1'b0;
			f_mode = M_NUM;
		end else begin
			f_kind = TOK_ERR;
			f_err  = ERR_UNKNOWN;
			f_mode = M_ERR;
		end
		f_tok.kind   = f_kind;
		f_tok.start  = pos_w[23:0];
		f_tok.length = (f_kind == TOK_ERR) ? 24'd0 : 24'd1;
		f_tok.err    = f_err;
		f_tok.last   = 1'b0;
	end

	always_comb begin
		t0        = '0;
		t0.start  = start_w[23:0];
		t0.length = 24'd1;
		t0_v      = 1'b0;
		use_f     = 1'b0;
		mode_d    = mode_q;
		case (mode_q)
			M_VAR, M_ANY: begin
				t0_v = 1'b1;
				if (is_aln) begin
					t0.kind   = TOK_ERR;
					t0.start  = pos_w[23:0];
					t0.length = 24'd0;
					t0.err    = (mode_q == M_VAR) ? ERR_VAR_ALN : ERR_ANY_ALN;
					mode_d    = M_ERR;
				end else begin
					t0.kind = (mode_q == M_VAR) ? TOK_VAR : TOK_ANY;
					use_f   = 1'b1;
				end
			end
			M_SLASH: begin
				t0_v    = 1'b1;
				t0.kind = is_dig ? TOK_ARITY : TOK_NAME;
				use_f   = 1'b1;
			end
			M_EQ, M_CMP: begin
				t0_v = 1'b1;
				if (byte_s1 == CH_EQ) begin
					t0.kind   = TOK_NAME;
					t0.length = 24'd2;
					mode_d    = M_IDLE;
				end else begin
					t0.kind = (mode_q == M_EQ) ? TOK_EQUAL : TOK_NAME;
					use_f   = 1'b1;
				end
			end
			M_BANG: begin
				t0_v = 1'b1;
				if (byte_s1 == CH_EQ) begin
					t0.kind   = TOK_NAME;
					t0.length = 24'd2;
					mode_d    = M_IDLE;
				end else begin
					t0.kind   = TOK_ERR;
					t0.length = 24'd0;
					t0.err    = ERR_BANG;
					mode_d    = M_ERR;
					use_f     = (byte_s1 == CH_NUL);
				end
			end
			M_NAME: begin
				if (!(is_aln || byte_s1 == CH_UNDER)) begin
					t0_v      = 1'b1;
					t0.kind   = TOK_NAME;
					t0.length = diff_w[23:0];
					use_f     = 1'b1;
				end
			end
			M_NUM: begin
				if (!is_dig) begin
					t0_v      = 1'b1;
					t0.kind   = TOK_NUM;
					t0.length = diff_w[23:0];
					use_f     = 1'b1;
				end
			end
			M_ERR: begin
				use_f = (byte_s1 == CH_NUL);
			end
			default: begin
				use_f = 1'b1;
			end
		endcase

		start_d = start_q;
		if (use_f) begin
			mode_d  = f_mode;
			start_d = pos_q;
		end
		if (byte_s1 == CH_NUL) begin
			mode_d  = M_IDLE;
			start_d = '0;
			pos_d   = '0;
		end else if (pos_q != '1) begin
			pos_d = pos_q + POS_BITS'(1);
		end else begin
			pos_d = pos_q;
		end
	end

	always_comb begin
		push    = '0;
		push.t0 = t0;
		push.t1 = f_tok;
		if (t0_v) begin
			if (use_f && f_emit) begin
				push.n       = 2'd2;
				push.t1.last = 1'b1;
			end else begin
				push.n       = 2'd1;
				push.t0.last = 1'b1;
			end
		end else if (use_f && f_emit) begin
			push.n       = 2'd1;
			push.t0      = f_tok;
			push.t0.last = 1'b1;
		end
		if (!valid_s1) begin
			push.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= M_IDLE;
			start_q  <= '0;
			pos_q    <= '0;
		end else begin
			valid_s1 <= in_valid && in_ready;
			if (valid_s1) begin
				mode_q  <= mode_d;
				start_q <= start_d;
				pos_q   <= pos_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= char_byte;
		end
	end

endmodule

[rtl/clx_fifo.sv]
module clx_fifo import clx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  clx_push_t            push,
	input  logic                 pop,
	output clx_tok_t             head,
	output logic                 not_empty,
	output logic [QCNT_BITS-1:0] count
);

	clx_tok_t             mem [QDEPTH];
	logic [QPTR_BITS-1:0] wr_q, rd_q;
	logic [QCNT_BITS-1:0] cnt_q;

	assign head      = mem[rd_q];
	assign not_empty = (cnt_q != '0);
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[wr_q] <= push.t0;
		end
		if (push.n == 2'd2) begin
			mem[wr_q + QPTR_BITS'(1)] <= push.t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_BITS'(push.n);
			if (pop) begin
				rd_q <= rd_q + QPTR_BITS'(1);
			end
			cnt_q <= cnt_q + QCNT_BITS'(push.n) - QCNT_BITS'(pop);
		end
	end

endmodule

[rtl/combinator_language_lexer_top.sv]
// Channel   Role     Payload
// text      sink     char_byte (8)
// tokens    source   token_kind (4), token_start (24), token_length (24), error_kind (3),
//                    last_of_run (1)
//
// One byte is accepted per cycle; it is registered, decoded against the lexer mode in the
// next cycle and its zero, one or two tokens are written into an eight-entry result queue.
// A token leaves the queue at most one per cycle, so the two tokens of a byte leave it in
// turn. Bytes are accepted while the queue has room for the tokens in flight.
// The asynchronous reset empties the queue and returns the lexer to idle at offset zero.
module combinator_language_lexer_top import clx_pkg::*; #(
	parameter int POS_BITS = POS_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	clx_byte_if.sink  text,
	clx_tok_if.source tokens
);

	clx_push_t            push;
	clx_tok_t             head;
	logic                 not_empty;
	logic [QCNT_BITS-1:0] q_count;

	clx_core #(.POS_BITS(POS_BITS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (text.valid),
		.char_byte (text.char_byte),
		.in_ready  (text.ready),
		.q_count   (q_count),
		.push      (push)
	);

	clx_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (tokens.valid && tokens.ready),
		.head      (head),
		.not_empty (not_empty),
		.count     (q_count)
	);

	assign tokens.valid        = not_empty;
	assign tokens.token_kind   = head.kind;
	assign tokens.token_start  = head.start;
	assign tokens.token_length = head.length;
	assign tokens.error_kind   = head.err;
	assign tokens.last_of_run  = head.last;

endmodule

[rtl/clx_check.sv]
module clx_check import clx_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        tok_valid,
	input logic        tok_ready,
	input logic [3:0]  tok_kind,
	input logic [23:0] tok_length,
	input logic [2:0]  tok_err,
	input logic        tok_last
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid)
		else $error("Token valid dropped before the transaction completed.");

	a_eof_shape: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_kind == TOK_EOF |-> tok_length == 24'd1 && tok_err == ERR_NONE
			&& tok_last)
		else $error("End of text token is malformed.");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_kind == TOK_ERR |-> tok_length == 24'd0 && tok_err != ERR_NONE)
		else $error("Error token is malformed.");

	a_noerr_code: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_kind != TOK_ERR |-> tok_err == ERR_NONE)
		else $error("Error code on a token that is not an error.");

endmodule

bind combinator_language_lexer_top clx_check u_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.tok_valid  (tokens.valid),
	.tok_ready  (tokens.ready),
	.tok_kind   (tokens.token_kind),
	.tok_length (tokens.token_length),
	.tok_err    (tokens.error_kind),
	.tok_last   (tokens.last_of_run)
);
